// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("property failed in same-cycle check");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("property failed in next-cycle check");

`endif

// ===== rtl/core/qpid_pkg.sv =====
// Shared constants and types of the quaternion PID controller.
package qpid_pkg;

	localparam int IN_W       = 16;  // quaternion component width
	localparam int GAIN_W     = 16;  // Q8.8 gain width
	localparam int OUT_W      = 32;  // drive width
	localparam int P_W        = 34;  // error product accumulator
	localparam int MAG_W      = 29;  // |p| >> 4
	localparam int SQ_W       = 59;  // sum of squared magnitudes
	localparam int ROOT_W     = 30;  // integer square root
	localparam int QUO_W      = 16;  // normalized magnitude quotient
	localparam int FRAC_SHIFT = 14;
	localparam int NUM_W      = MAG_W + FRAC_SHIFT;
	localparam int CLAMP_W    = 61;  // gain products clamp at 2^60
	localparam int ACC_W      = 64;
	localparam int GAIN_SHIFT = 8;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	localparam int COMPONENT_WIDTH_DEF = 16;
	localparam int SUM_WIDTH_DEF       = 32;

	localparam logic [GAIN_W-1:0] KP_RESET = 16'd256;
	localparam logic [GAIN_W-1:0] KI_RESET = 16'd0;
	localparam logic [GAIN_W-1:0] KD_RESET = 16'd0;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_KP = 2'd0;
	localparam logic [1:0] REG_KI = 2'd1;
	localparam logic [1:0] REG_KD = 2'd2;

	// gain term under work
	localparam logic [1:0] TERM_P = 2'd0;
	localparam logic [1:0] TERM_I = 2'd1;
	localparam logic [1:0] TERM_D = 2'd2;

	// Product term signs of target * conj(measured): bit 4*c+j set when
	// the term of component c with target index j is subtracted.
	localparam logic [15:0] TERM_NEG = 16'h3950;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PROD  = 8'b0000_0010,
		S_SQ    = 8'b0000_0100,
		S_ROOT  = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_INTEG = 8'b0010_0000,
		S_GMUL  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} qpid_state_t;

endpackage

// ===== rtl/core/quaternion_pid_attitude_controller_core.sv =====
// Quaternion-error PID attitude controller: sequencer, state and bus ports.
// Work per item: error products and squares, then a bit-serial square root and four
// divides (both skipped when the error norm is zero), then twelve gain products.
// One item at a time: the next input is taken once the result is queued.
// Reset (arst_n low): idle, output empty, gains 1.0/0/0, sums and previous errors zero.
module quaternion_pid_attitude_controller_core
	import qpid_pkg::*;
#(
	parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
	parameter int SUM_WIDTH       = SUM_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	// target_w, target_x, target_y, target_z, measured_w, measured_x,
	// measured_y, measured_z (16 bits each, lowest first)
	input  logic [8*IN_W-1:0]   s_tdata,
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	// drive_w, drive_x, drive_y, drive_z (32 bits each, lowest first)
	output logic [4*OUT_W-1:0]  m_tdata,
	// zero_norm
	output logic                m_tuser,
	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	localparam int CW = COMPONENT_WIDTH;
	localparam int SW = SUM_WIDTH;
	localparam int MW = (SW > CW + 1) ? SW : CW + 1;   // gain operand width
	localparam int XW = (CW > QUO_W + 2) ? CW : QUO_W + 2;
	localparam int TW = ((SW > CW) ? SW : CW) + 1;
	localparam logic signed [XW-1:0] E_MAX = (XW'(1) << (CW - 1)) - XW'(1);
	localparam logic signed [XW-1:0] E_MIN = -E_MAX - XW'(1);
	localparam logic signed [TW-1:0] S_MAX = (TW'(1) << (SW - 1)) - TW'(1);
	localparam logic signed [TW-1:0] S_MIN = -S_MAX - TW'(1);
	localparam logic signed [ACC_W-1:0] R_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] R_MIN = -R_MAX - ACC_W'(1);

	qpid_state_t state_q;

	// configuration
	logic [GAIN_W-1:0] kp_q, ki_q, kd_q;

	// item registers
	logic signed [IN_W-1:0]  t_q [4];
	logic signed [IN_W-1:0]  m_q [4];
	logic signed [P_W-1:0]   p_q [4];
	logic signed [CW-1:0]    e_q [4];
	logic signed [SW-1:0]    sum_q [4];
	logic signed [CW-1:0]    last_q [4];
	logic [OUT_W-1:0]        res_q [4];
	logic [SQ_W-1:0]         sq_q;
	logic [ROOT_W-1:0]       norm_q;
	logic signed [CW:0]      d_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    zero_q;
	logic [3:0]              cnt_q;
	logic [1:0]              comp_q;
	logic [1:0]              term_q;
	logic                    root_go_q, div_go_q, mul_go_q;

	// output register
	logic                    m_tvalid_q;
	logic [4*OUT_W-1:0]      m_tdata_q;
	logic                    m_tuser_q;

	// unit connections
	logic [ROOT_W-1:0]  root;
	logic               root_done;
	logic [QUO_W-1:0]   quo;
	logic               div_done;
	logic [CLAMP_W-1:0] prod;
	logic               mul_done;

	// datapath
	logic [1:0]              pc, pj;
	logic signed [2*IN_W-1:0] pterm;
	logic signed [P_W-1:0]   p_sel, p_abs;
	logic [MAG_W-1:0]        mag_sel;
	logic [2*MAG_W-1:0]      mag_sq;
	logic [SQ_W-1:0]         sq_next;
	logic [NUM_W-1:0]        div_num;
	logic signed [XW-1:0]    q_pos, q_val;
	logic signed [CW-1:0]    e_new;
	logic signed [TW-1:0]    s_wide;
	logic signed [SW-1:0]    s_new;
	logic signed [MW-1:0]    op;
	logic [MW-1:0]           op_mag;
	logic [GAIN_W-1:0]       gain_sel;
	logic signed [ACC_W-1:0] term, acc_next, acc_shr;
	logic [OUT_W-1:0]        r_sat;
	logic                    slot_free;
	logic                    in_acc;

	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign slot_free = !m_tvalid_q || m_tready;

	// error product term: target[j] * measured[c ^ j]
	assign pc    = cnt_q[3:2];
	assign pj    = cnt_q[1:0];
	assign pterm = t_q[pj] * m_q[pc ^ pj];

	// magnitude of the selected product component, scaled down by 16
	assign p_sel   = p_q[(state_q == S_SQ) ? cnt_q[1:0] : comp_q];
	assign p_abs   = p_sel[P_W-1] ? -p_sel : p_sel;
	assign mag_sel = p_abs[MAG_W+3:4];
	assign mag_sq  = mag_sel * mag_sel;
	assign sq_next = sq_q + SQ_W'(mag_sq);

	// round-half-up normalization dividend
	assign div_num = {mag_sel, {FRAC_SHIFT{1'b0}}} + NUM_W'(norm_q[ROOT_W-1:1]);

	// signed, saturated error component
	always_comb begin
		q_pos = XW'(quo);
		q_val = p_sel[P_W-1] ? -q_pos : q_pos;
		if (q_val > E_MAX) begin
			e_new = E_MAX[CW-1:0];
		end else if (q_val < E_MIN) begin
			e_new = E_MIN[CW-1:0];
		end else begin
			e_new = q_val[CW-1:0];
		end
	end

	// saturating running sum
	always_comb begin
		s_wide = TW'(sum_q[comp_q]) + TW'(e_q[comp_q]);
		if (s_wide > S_MAX) begin
			s_new = S_MAX[SW-1:0];
		end else if (s_wide < S_MIN) begin
			s_new = S_MIN[SW-1:0];
		end else begin
			s_new = s_wide[SW-1:0];
		end
	end

	// gain operand for the term under work
	always_comb begin
		case (term_q)
			TERM_P: begin
				op       = MW'(e_q[comp_q]);
				gain_sel = kp_q;
			end
			TERM_I: begin
				op       = MW'(sum_q[comp_q]);
				gain_sel = ki_q;
			end
			default: begin
				op       = MW'(d_q);
				gain_sel = kd_q;
			end
		endcase
		op_mag = op[MW-1] ? MW'(-op) : MW'(op);
	end

	// signed term, total, floor shift by 8 and 32-bit saturation
	always_comb begin
		term     = op[MW-1] ? -$signed(ACC_W'(prod)) : $signed(ACC_W'(prod));
		acc_next = acc_q + term;
		acc_shr  = acc_next >>> GAIN_SHIFT;
		if (acc_shr > R_MAX) begin
			r_sat = R_MAX[OUT_W-1:0];
		end else if (acc_shr < R_MIN) begin
			r_sat = R_MIN[OUT_W-1:0];
		end else begin
			r_sat = acc_shr[OUT_W-1:0];
		end
	end

	qpid_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_go_q),
		.value  (sq_q),
		.root   (root),
		.done   (root_done)
	);

	qpid_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_num),
		.den    (norm_q),
		.quo    (quo),
		.done   (div_done)
	);

	qpid_gmul #(
		.MW (MW)
	) u_gmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go_q),
		.gain   (gain_sel),
		.mag    (op_mag),
		.prod   (prod),
		.done   (mul_done)
	);

	// register writes; paddr[3:2] selects, writes past the last register drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= KP_RESET;
			ki_q <= KI_RESET;
			kd_q <= KD_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_KP:  kp_q <= pwdata[GAIN_W-1:0];
				REG_KI:  ki_q <= pwdata[GAIN_W-1:0];
				REG_KD:  kd_q <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_KP:  prdata = DATA_W'(kp_q);
			REG_KI:  prdata = DATA_W'(ki_q);
			REG_KD:  prdata = DATA_W'(kd_q);
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			comp_q     <= '0;
			term_q     <= TERM_P;
			root_go_q  <= 1'b0;
			div_go_q   <= 1'b0;
			mul_go_q   <= 1'b0;
			zero_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				sum_q[i]  <= '0;
				last_q[i] <= '0;
			end
		end else begin
			root_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			mul_go_q  <= 1'b0;
			// drop the result once taken, unless a new one is queued this cycle
			if (m_tready && !(state_q == S_DONE && slot_free)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q   <= '0;
						state_q <= S_PROD;
					end
				end
				S_PROD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'hF) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[1:0] == 2'd3) begin
						comp_q <= '0;
						zero_q <= (sq_next == '0);
						if (sq_next == '0) begin
							state_q <= S_INTEG;
						end else begin
							root_go_q <= 1'b1;
							state_q   <= S_ROOT;
						end
					end
				end
				S_ROOT: begin
					if (root_done) begin
						div_go_q <= 1'b1;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						comp_q <= comp_q + 1'b1;
						if (comp_q == 2'd3) begin
							state_q <= S_INTEG;
						end else begin
							div_go_q <= 1'b1;
						end
					end
				end
				S_INTEG: begin
					sum_q[comp_q]  <= s_new;
					last_q[comp_q] <= e_q[comp_q];
					term_q         <= TERM_P;
					mul_go_q       <= 1'b1;
					state_q        <= S_GMUL;
				end
				S_GMUL: begin
					if (mul_done) begin
						if (term_q == TERM_D) begin
							comp_q  <= comp_q + 1'b1;
							state_q <= (comp_q == 2'd3) ? S_DONE : S_INTEG;
						end else begin
							term_q   <= term_q + 1'b1;
							mul_go_q <= 1'b1;
						end
					end
				end
				S_DONE: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					for (int i = 0; i < 4; i++) begin
						t_q[i] <= s_tdata[i*IN_W +: IN_W];
						m_q[i] <= s_tdata[(i+4)*IN_W +: IN_W];
						p_q[i] <= '0;
					end
					sq_q <= '0;
				end
			end
			S_PROD: begin
				if (TERM_NEG[cnt_q]) begin
					p_q[pc] <= p_q[pc] - P_W'(pterm);
				end else begin
					p_q[pc] <= p_q[pc] + P_W'(pterm);
				end
			end
			S_SQ: begin
				sq_q <= sq_next;
				if (cnt_q[1:0] == 2'd3 && sq_next == '0) begin
					for (int i = 0; i < 4; i++) begin
						e_q[i] <= '0;
					end
				end
			end
			S_ROOT: begin
				if (root_done) begin
					norm_q <= root;
				end
			end
			S_DIV: begin
				if (div_done) begin
					e_q[comp_q] <= e_new;
				end
			end
			S_INTEG: begin
				d_q   <= (CW+1)'(e_q[comp_q]) - (CW+1)'(last_q[comp_q]);
				acc_q <= '0;
			end
			S_GMUL: begin
				if (mul_done) begin
					acc_q <= acc_next;
					if (term_q == TERM_D) begin
						res_q[comp_q] <= r_sat;
					end
				end
			end
			S_DONE: begin
				if (slot_free) begin
					m_tdata_q <= {res_q[3], res_q[2], res_q[1], res_q[0]};
					m_tuser_q <= zero_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== rtl/core/qpid_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module qpid_isqrt
	import qpid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   value,
	output logic [ROOT_W-1:0] root,
	output logic              done
);

	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] pwr_q;
	logic [SQ_W-1:0] trial;
	logic            busy_q;
	logic            done_q;

	assign trial = res_q + pwr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && pwr_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			res_q <= '0;
			pwr_q <= {1'b1, {(SQ_W-1){1'b0}}};
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + pwr_q;
			end else begin
				res_q <= res_q >> 1;
			end
			pwr_q <= pwr_q >> 2;
		end
	end

	assign root = res_q[ROOT_W-1:0];
	assign done = done_q;

endmodule

// ===== rtl/core/qpid_div.sv =====
// Restoring divider, one quotient bit per cycle.
module qpid_div
	import qpid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [ROOT_W-1:0] den,
	output logic [QUO_W-1:0]  quo,
	output logic              done
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [ROOT_W-1:0] rem_q;
	logic [QUO_W-1:0]  low_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ROOT_W:0]   shifted;
	logic              busy_q;
	logic              done_q;

	assign shifted = {rem_q, low_q[QUO_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// the upper dividend bits stay below den since the quotient fits QUO_W bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ROOT_W'(num[NUM_W-1:QUO_W]);
			low_q <= num[QUO_W-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			low_q <= low_q << 1;
			if (shifted >= {1'b0, den}) begin
				rem_q <= ROOT_W'(shifted - {1'b0, den});
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[ROOT_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ===== rtl/core/qpid_gmul.sv =====
// Shift-add gain multiplier with clamp at 2^60, one gain bit per cycle.
module qpid_gmul
	import qpid_pkg::*;
#(
	parameter int MW = 33
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [GAIN_W-1:0]  gain,
	input  logic [MW-1:0]      mag,
	output logic [CLAMP_W-1:0] prod,
	output logic               done
);

	localparam int AW    = (MW + GAIN_W > CLAMP_W) ? MW + GAIN_W : CLAMP_W;
	localparam int CNT_W = $clog2(GAIN_W + 1);
	localparam logic [AW-1:0] CAP = AW'(1) << (CLAMP_W - 1);

	logic [AW-1:0]     acc_q;
	logic [GAIN_W-1:0] g_q;
	logic [MW-1:0]     m_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(GAIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// MSB first: double, then add the operand when the gain bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			g_q   <= gain;
			m_q   <= mag;
		end else if (busy_q) begin
			acc_q <= (acc_q << 1) + (g_q[GAIN_W-1] ? AW'(m_q) : AW'(0));
			g_q   <= g_q << 1;
		end
	end

	assign prod = (acc_q > CAP) ? CAP[CLAMP_W-1:0] : acc_q[CLAMP_W-1:0];
	assign done = done_q;

endmodule

// ===== rtl/core/qpid_checker.sv =====
// Port-level checker for the quaternion PID controller, with its bind.
`include "assert_macros.svh"

module qpid_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic         m_tuser
);

	// an accepted item keeps the input closed while it is worked on
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// a new result is queued only as the sequencer returns to idle
	`ASSERT_SAME(a_idle_with_result, clk, arst_n, $rose(m_tvalid), s_tready)

	// a stalled result holds
	`ASSERT_NEXT(a_result_holds, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind quaternion_pid_attitude_controller_core qpid_checker u_qpid_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
